// ----- sv/sctk_pkg.sv -----
// sctk_pkg: shared types, scan code constants and set-1 key tables
// for the scan code translator and key fifo; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sctk_pkg;

    // operation codes of an input beat
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_POP   = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ARROW_UP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ARROW_DOWN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARROW_LEFT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARROW_RIGHT = 2'd3;

    localparam logic [7:0] ARROW_UP_RST    = 8'd128;
    localparam logic [7:0] ARROW_DOWN_RST  = 8'd129;
    localparam logic [7:0] ARROW_LEFT_RST  = 8'd130;
    localparam logic [7:0] ARROW_RIGHT_RST = 8'd131;

    // set-1 make codes with special handling
    localparam logic [7:0] SC_LSHIFT = 8'h2A;
    localparam logic [7:0] SC_RSHIFT = 8'h36;
    localparam logic [7:0] SC_UP     = 8'h48;
    localparam logic [7:0] SC_DOWN   = 8'h50;
    localparam logic [7:0] SC_LEFT   = 8'h4B;
    localparam logic [7:0] SC_RIGHT  = 8'h4D;
    localparam logic [7:0] CHAR_NONE = 8'h00;

    // populated part of the us key tables, codes past the end map to none
    localparam int MAP_LEN = 58;

    localparam logic [7:0] PLAIN_MAP [MAP_LEN] = '{
        8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
        8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
        8'h00, 8'h20
    };

    localparam logic [7:0] SHIFT_MAP [MAP_LEN] = '{
        8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
        8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
        8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
        8'h00, 8'h20
    };

    // character of a plain press, scan code below 128
    function automatic logic [7:0] sctk_key_char(input logic [6:0] code, input logic shifted);
        logic [7:0] ch;
        ch = CHAR_NONE;
        if (code < 7'(MAP_LEN))
        begin
            ch = shifted ? SHIFT_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
        end
        return ch;
    endfunction

    // controller to datapath commands
    typedef struct packed {
        logic take;   // input beat accepted this cycle
        logic load;   // load the output register
    } sctk_cmd_t;

endpackage

`default_nettype wire

// ----- sv/sctk_ctrl.sv -----
// sctk_ctrl: handshake controller, accept -> read -> hold sequence
// depends on sctk_pkg
`timescale 1ns / 1ps
`default_nettype none

module sctk_ctrl
    import sctk_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    output sctk_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_HOLD
    } state_t;

    state_t state_reg;
    logic   in_stall_reg;
    logic   out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_stall_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg    <= ST_READ;
                        in_stall_reg <= 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg     <= ST_HOLD;
                    out_valid_reg <= 1'b1;
                end
                ST_HOLD:
                begin
                    if (!out_stall)
                    begin
                        state_reg     <= ST_IDLE;
                        out_valid_reg <= 1'b0;
                        in_stall_reg  <= 1'b0;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;
    assign cmd.take  = (state_reg == ST_IDLE) && in_valid;
    assign cmd.load  = (state_reg == ST_READ);

    // one beat in flight: a result shows only while input is held off
    a_valid_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall_reg)
        else $error("result shown while input open");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> out_valid_reg)
        else $error("loaded result not shown");

    a_reopen_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall_reg) |-> $past(out_valid_reg && !out_stall))
        else $error("input reopened without output beat");

endmodule

`default_nettype wire

// ----- sv/sctk_datapath.sv -----
// sctk_datapath: translation, shift flag, arrow registers, ring fifo memory
// and output register; depends on sctk_pkg
`timescale 1ns / 1ps
`default_nettype none

module sctk_datapath
    import sctk_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sctk_cmd_t            cmd,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 operation,
    input  wire logic [7:0]           scancode,
    input  wire logic                 release_req,
    input  wire logic                 extended,
    input  wire logic [31:0]          payload,
    input  wire logic [31:0]          timestamp,
    output logic                      stored,
    output logic                      popped,
    output logic [31:0]               out_payload,
    output logic [31:0]               out_timestamp,
    output logic [7:0]                out_char
);

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam logic [PW-1:0] LAST = PW'(FIFO_DEPTH - 1);

    logic [31:0] payload_mem [FIFO_DEPTH];
    logic [31:0] time_mem    [FIFO_DEPTH];
    logic [7:0]  char_mem    [FIFO_DEPTH];

    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic          shift_reg, shift_next;
    logic [7:0]    up_reg, down_reg, left_reg, right_reg;

    logic          op_reg;
    logic          hit_reg, hit_next;
    logic [31:0]   rd_payload_reg;
    logic [31:0]   rd_time_reg;
    logic [7:0]    rd_char_reg;

    logic          stored_reg, popped_reg;
    logic [31:0]   out_payload_reg, out_timestamp_reg;
    logic [7:0]    out_char_reg;

    logic          empty, full, keep, push, pop;
    logic [7:0]    ev_char, arrow_char;
    logic          is_shift_key;

    assign rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
    assign wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
    assign empty       = (rd_ptr_reg == wr_ptr_reg);
    assign full        = (wr_ptr_next == rd_ptr_reg);
    assign is_shift_key = (scancode == SC_LSHIFT) || (scancode == SC_RSHIFT);

    always_comb
    begin
        priority if (scancode == SC_UP)    arrow_char = up_reg;
        else if (scancode == SC_DOWN)      arrow_char = down_reg;
        else if (scancode == SC_LEFT)      arrow_char = left_reg;
        else if (scancode == SC_RIGHT)     arrow_char = right_reg;
        else                               arrow_char = CHAR_NONE;
    end

    // event translation
    always_comb
    begin
        ev_char    = CHAR_NONE;
        keep       = 1'b1;
        shift_next = shift_reg;
        priority if (extended)
        begin
            ev_char = release_req ? CHAR_NONE : arrow_char;
        end
        else if (is_shift_key)
        begin
            shift_next = !release_req;
        end
        else if (release_req)
        begin
            ev_char = CHAR_NONE;
        end
        else if (scancode[7])
        begin
            keep = 1'b0;
        end
        else
        begin
            ev_char = sctk_key_char(scancode[6:0], shift_reg);
            keep    = (ev_char != CHAR_NONE);
        end
    end

    assign push     = cmd.take && (operation == OP_EVENT) && keep && !full;
    assign pop      = cmd.take && (operation == OP_POP) && !empty;
    assign hit_next = (operation == OP_POP) ? !empty : (keep && !full);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            shift_reg  <= 1'b0;
            up_reg     <= ARROW_UP_RST;
            down_reg   <= ARROW_DOWN_RST;
            left_reg   <= ARROW_LEFT_RST;
            right_reg  <= ARROW_RIGHT_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ARROW_UP:    up_reg    <= cfg_data;
                    REG_ARROW_DOWN:  down_reg  <= cfg_data;
                    REG_ARROW_LEFT:  left_reg  <= cfg_data;
                    REG_ARROW_RIGHT: right_reg <= cfg_data;
                    default:         up_reg    <= up_reg;
                endcase
            end
            if (cmd.take && (operation == OP_EVENT))
            begin
                shift_reg <= shift_next;
            end
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    // ring memory, registered read
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            payload_mem[wr_ptr_reg] <= payload;
            time_mem[wr_ptr_reg]    <= timestamp;
            char_mem[wr_ptr_reg]    <= ev_char;
        end
        if (pop)
        begin
            rd_payload_reg <= payload_mem[rd_ptr_reg];
            rd_time_reg    <= time_mem[rd_ptr_reg];
            rd_char_reg    <= char_mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg  <= operation;
            hit_reg <= hit_next;
        end
        if (cmd.load)
        begin
            stored_reg        <= (op_reg == OP_EVENT) && hit_reg;
            popped_reg        <= (op_reg == OP_POP) && hit_reg;
            out_payload_reg   <= ((op_reg == OP_POP) && hit_reg) ? rd_payload_reg : '0;
            out_timestamp_reg <= ((op_reg == OP_POP) && hit_reg) ? rd_time_reg : '0;
            out_char_reg      <= ((op_reg == OP_POP) && hit_reg) ? rd_char_reg : CHAR_NONE;
        end
    end

    assign stored        = stored_reg;
    assign popped        = popped_reg;
    assign out_payload   = out_payload_reg;
    assign out_timestamp = out_timestamp_reg;
    assign out_char      = out_char_reg;

    a_push_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (wr_ptr_reg != rd_ptr_reg))
        else $error("fifo empty after push");

    a_empty_pop_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.take && (operation == OP_POP) && empty) |=> $stable(rd_ptr_reg))
        else $error("read pointer moved on empty pop");

    a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("push and pop in one cycle");

endmodule

`default_nettype wire

// ----- sv/scancode_translate_key_fifo.sv -----
// scancode_translate_key_fifo: set-1 scan code translator with a ring fifo
// top level; instantiates sctk_ctrl and sctk_datapath, depends on sctk_pkg
//
//  channel  | handshake           | fields
//  ---------+---------------------+------------------------------------------------
//  input    | in_valid / in_stall | operation scancode release_req extended
//           |                     | payload timestamp
//  output   | out_valid/out_stall | stored popped out_payload out_timestamp out_char
//  config   | cfg_we              | cfg_index cfg_data (write only)
//
// each beat passes through accept with fifo write or read, output register
// load and result hold; the input stays stalled until the result beat is taken,
// so one beat is in flight and an output stall lengthens the result hold
// reset clears pointers and shift flag and restores the default arrow codes;
// fifo memory is not cleared
// an output stall holds the result and keeps the input stalled
`timescale 1ns / 1ps
`default_nettype none

module scancode_translate_key_fifo
    import sctk_pkg::*;
#(
    parameter int FIFO_DEPTH = 64
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration writes
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    // input beats
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire logic [7:0]           scancode,
    input  wire logic                 release_req,
    input  wire logic                 extended,
    input  wire logic [31:0]          payload,
    input  wire logic [31:0]          timestamp,
    // result beats
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      stored,
    output logic                      popped,
    output logic [31:0]               out_payload,
    output logic [31:0]               out_timestamp,
    output logic [7:0]                out_char
);

    sctk_cmd_t cmd;

    // sequencing of accept, read and output hold
    sctk_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // translation, shift tracking and the ring buffer
    sctk_datapath #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .scancode      (scancode),
        .release_req   (release_req),
        .extended      (extended),
        .payload       (payload),
        .timestamp     (timestamp),
        .stored        (stored),
        .popped        (popped),
        .out_payload   (out_payload),
        .out_timestamp (out_timestamp),
        .out_char      (out_char)
    );

endmodule

`default_nettype wire
